FILE: rtl/core/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, character codes and status codes of the expression checker.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Longest expression that gets distinct positions.
  localparam int ESC_MAX_LEN = 4096;

  // Character codes.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // Status codes.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_UNKNOWN     = 4'd1;
  localparam logic [3:0] ST_DOUBLE_OP   = 4'd2;
  localparam logic [3:0] ST_NO_OP_LEFT  = 4'd3;
  localparam logic [3:0] ST_NO_OP_RIGHT = 4'd4;
  localparam logic [3:0] ST_EMPTY       = 4'd5;
  localparam logic [3:0] ST_OP_AFTER_LP = 4'd6;
  localparam logic [3:0] ST_OP_BEFORE_RP = 4'd7;
  localparam logic [3:0] ST_RP_LP       = 4'd8;
  localparam logic [3:0] ST_LEAD_BINOP  = 4'd9;
  localparam logic [3:0] ST_LEAD_RP     = 4'd10;
  localparam logic [3:0] ST_TRAIL_OP    = 4'd11;

  // One input item.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  status;
    logic [11:0] position;
  } out_item_t;

  // Verdict on one judged character.
  typedef struct packed {
    logic        hit;
    logic [3:0]  code;
    logic [11:0] pos;
  } verdict_t;

  // True for the five arithmetic operators.
  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_CARET);
  endfunction

endpackage

FILE: rtl/core/esc_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_judge
// Judges one character against its left and right non-space neighbors.
// ----------------------------------------------------------------------------
module esc_judge import esc_pkg::*; #(
  parameter int IW = 13
) (
  input  logic [7:0]  c,
  input  logic [IW:0] idx,
  input  logic [7:0]  p,
  input  logic        p_open,
  input  logic [7:0]  n,
  input  logic        closer,
  output verdict_t    verdict
);

  localparam int PW = (IW + 1 > 12) ? IW + 1 : 12;

  logic [PW-1:0] idx_w;
  logic [11:0]   pos_m1;
  logic [11:0]   pos_m2;

  // Positions one and two before the wrapped index, kept to 12 bits.
  assign idx_w  = PW'(idx);
  assign pos_m1 = 12'(idx_w - PW'(1));
  assign pos_m2 = 12'(idx_w - PW'(2));

  // Rules for the character, in the order they take precedence.
  always_comb begin
    verdict = '0;
    if (((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT)) begin
      verdict.hit = 1'b0;
    end else if (c == CH_LPAREN) begin
      if ((idx != '0) && !is_op(p) && (p != CH_LPAREN)) begin
        verdict = '{1'b1, ST_NO_OP_LEFT, pos_m1};
      end else if ((n == CH_STAR) || (n == CH_SLASH) || (n == CH_CARET)) begin
        if (idx == '0) verdict = '{1'b1, ST_LEAD_BINOP, 12'd0};
        else           verdict = '{1'b1, ST_OP_AFTER_LP, pos_m1};
      end
    end else if (c == CH_RPAREN) begin
      if ((p == CH_LPAREN) && !closer) begin
        if (p_open) verdict = '{1'b1, ST_LEAD_RP, pos_m1};
        else        verdict = '{1'b1, ST_EMPTY, pos_m2};
      end else if (!closer && !is_op(n) && (n != CH_RPAREN)) begin
        if (n == CH_LPAREN) verdict = '{1'b1, ST_RP_LP, pos_m1};
        else                verdict = '{1'b1, ST_NO_OP_RIGHT, pos_m1};
      end else if (is_op(p)) begin
        if (closer) verdict = '{1'b1, ST_TRAIL_OP, pos_m2};
        else        verdict = '{1'b1, ST_OP_BEFORE_RP, pos_m1};
      end
    end else if (!is_op(c)) begin
      verdict = '{1'b1, ST_UNKNOWN, pos_m1};
    end else if (is_op(n)) begin
      verdict = '{1'b1, ST_DOUBLE_OP, pos_m1};
    end
  end

endmodule

FILE: rtl/core/expression_syntax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_syntax_checker
// Streams expression characters and reports the first syntax error or success.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready   | in_item_t  {ch, last}
//  out     | output    | out_valid / out_ready | out_item_t {status, position}
//
// One item per cycle unless a held result stalls an item with last set; in the
// input register the checker judges each item against the held neighbor character
// and updates its state. An item with last set writes one result into the output
// register as it leaves the input register. Reset clears the state to the implied
// opening parenthesis; the block is ready in the first cycle after reset. Only a held
// result stalls an item with last set; other items pass regardless of out_ready.
// ----------------------------------------------------------------------------
module expression_syntax_checker import esc_pkg::*; #(
  parameter int MAX_LEN = ESC_MAX_LEN
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IW = $clog2(MAX_LEN + 1);

  // Input register.
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_fire;

  // Checker state.
  logic [7:0]    pending_char, pending_char_next;
  logic [IW-1:0] pending_index, pending_index_next;
  logic [7:0]    left_char, left_char_next;
  logic          left_is_opener, left_is_opener_next;
  logic [IW-1:0] char_index, char_index_next;
  logic          err_seen, err_seen_next;
  logic [3:0]    err_code, err_code_next;
  logic [11:0]   err_pos, err_pos_next;

  logic          is_space;
  logic [7:0]    new_pending;
  logic [IW-1:0] new_pindex;
  logic [7:0]    new_left;
  logic          new_lopen;
  verdict_t      v_adv, v_pend, v_close;

  // The input register moves on unless a result for it cannot be written.
  assign s1_fire  = s1_valid && (!s1_item.last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  // Neighbors after the current character has become pending.
  assign is_space    = (s1_item.ch == CH_SPACE);
  assign new_pending = is_space ? pending_char : s1_item.ch;
  assign new_pindex  = is_space ? pending_index : char_index;
  assign new_left    = is_space ? left_char : pending_char;
  assign new_lopen   = is_space ? left_is_opener : (pending_index == '0);

  // Old pending character judged against the incoming one.
  esc_judge #(.IW(IW)) u_judge_adv (
    .c       (pending_char),
    .idx     ({1'b0, pending_index}),
    .p       (left_char),
    .p_open  (left_is_opener),
    .n       (s1_item.ch),
    .closer  (1'b0),
    .verdict (v_adv)
  );

  // Pending character judged against the implied closer.
  esc_judge #(.IW(IW)) u_judge_pend (
    .c       (new_pending),
    .idx     ({1'b0, new_pindex}),
    .p       (new_left),
    .p_open  (new_lopen),
    .n       (CH_RPAREN),
    .closer  (1'b0),
    .verdict (v_pend)
  );

  // The implied closer itself.
  esc_judge #(.IW(IW)) u_judge_close (
    .c       (CH_RPAREN),
    .idx     ({1'b0, char_index} + (IW + 1)'(1)),
    .p       (new_pending),
    .p_open  (new_pindex == '0),
    .n       (CH_NONE),
    .closer  (1'b1),
    .verdict (v_close)
  );

  // Keep the first error and advance the neighbor window.
  always_comb begin
    err_seen_next       = err_seen;
    err_code_next       = err_code;
    err_pos_next        = err_pos;
    pending_char_next   = new_pending;
    pending_index_next  = new_pindex;
    left_char_next      = new_left;
    left_is_opener_next = new_lopen;
    char_index_next     = (char_index < IW'(MAX_LEN)) ? char_index + IW'(1) : char_index;
    priority if (err_seen) begin
      err_seen_next = 1'b1;
    end else if (!is_space && v_adv.hit) begin
      err_seen_next = 1'b1;
      err_code_next = v_adv.code;
      err_pos_next  = v_adv.pos;
    end else if (s1_item.last && v_pend.hit) begin
      err_seen_next = 1'b1;
      err_code_next = v_pend.code;
      err_pos_next  = v_pend.pos;
    end else if (s1_item.last && v_close.hit) begin
      err_seen_next = 1'b1;
      err_code_next = v_close.code;
      err_pos_next  = v_close.pos;
    end else begin
      err_seen_next = 1'b0;
    end
  end

  // State registers; the end of an expression returns them to reset.
  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_item.last)) begin
      pending_char   <= CH_LPAREN;
      pending_index  <= '0;
      left_char      <= CH_NONE;
      left_is_opener <= 1'b0;
      char_index     <= IW'(1);
      err_seen       <= 1'b0;
      err_code       <= ST_OK;
      err_pos        <= '0;
    end else if (s1_fire) begin
      pending_char   <= pending_char_next;
      pending_index  <= pending_index_next;
      left_char      <= left_char_next;
      left_is_opener <= left_is_opener_next;
      char_index     <= char_index_next;
      err_seen       <= err_seen_next;
      err_code       <= err_code_next;
      err_pos        <= err_pos_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_item.last) begin
      out_data.status   <= err_seen_next ? err_code_next : ST_OK;
      out_data.position <= err_seen_next ? err_pos_next : 12'd0;
    end
  end

`ifndef SYNTH
  // An expression end brings the window back to the implied opener.
  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.last) |=> (pending_char == CH_LPAREN) && (pending_index == '0))
    else $error("state not cleared after final item");

  // The character index saturates at the maximum length.
  a_index_saturates: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_item.last && (char_index == IW'(MAX_LEN))) |=>
    (char_index == IW'(MAX_LEN)))
    else $error("character index passed its limit");

  // A held item in the input register is not dropped or altered.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_item)))
    else $error("stalled item lost");

  // A recorded error always carries a failing status.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    err_seen |-> (err_code != ST_OK))
    else $error("error flag without error code");
`endif

endmodule
